@@ src/scs_pkg.sv @@
package scs_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int TICK_BITS_DEF  = 32;

    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 88;
    localparam int PADDR_BITS   = 3;

    localparam logic [7:0] STOP_PAYLOAD     = 8'd100;
    localparam logic [5:0] REPORT_CODE_MASK = 6'h3F;

    typedef enum logic [2:0] {
        ACT_SINGLE  = 3'd0,
        ACT_BURST   = 3'd1,
        ACT_STOP    = 3'd2,
        ACT_RAW     = 3'd3,
        ACT_REPORT  = 3'd4,
        ACT_STORAGE = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        RC_OK          = 3'd0,
        RC_NOT_ENABLED = 3'd1,
        RC_WRONG_STATE = 3'd2,
        RC_NO_STORAGE  = 3'd3,
        RC_NO_SPACE    = 3'd4,
        RC_UNKNOWN     = 3'd5,
        RC_BAD_REPORT  = 3'd6
    } result_code_t;

    typedef enum logic [2:0] {
        CMD_SINGLE  = 3'd0,
        CMD_BURST   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_RAW     = 3'd3,
        CMD_STORAGE = 3'd4
    } cmd_id_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SINGLE   = 2'd1,
        ST_BURST    = 2'd2,
        ST_STOPPING = 2'd3
    } cap_state_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NO_STORAGE = 3'd1,
        ERR_NO_SPACE   = 3'd2,
        ERR_CAPTURE    = 3'd3,
        ERR_WRITE      = 3'd4,
        ERR_ENCODE     = 3'd5,
        ERR_CREATE     = 3'd6
    } error_t;

    localparam logic [5:0] REP_SINGLE_DONE  = 6'd1;
    localparam logic [5:0] REP_BURST_DONE   = 6'd2;
    localparam logic [5:0] REP_CAPTURE_FAIL = 6'd3;
    localparam logic [5:0] REP_CREATE_FAIL  = 6'd6;

    localparam logic [PADDR_BITS-3:0] REG_ENABLED = 1'b0;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  flags;
        logic [15:0] status_word;
        logic        storage_ready;
        logic        space_ok;
        logic [31:0] now_tick;
    } item_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        cmd_valid;
        logic [2:0]  cmd_id;
        logic [7:0]  cmd_payload;
        logic        state_event;
        logic        picture_event;
        logic [15:0] picture_code;
        logic [1:0]  cap_state;
        logic [15:0] picture_count;
        logic [2:0]  err_latched;
        logic        raw_mode;
        logic [31:0] elapsed_ticks;
    } result_t;

endpackage

@@ src/scs_cfg.sv @@
module scs_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scs_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              enabled
);

    logic enabled_reg;
    logic enabled_next;
    logic sel_enabled;

    assign pready      = 1'b1;
    assign sel_enabled = (paddr[scs_pkg::PADDR_BITS-1:2] == scs_pkg::REG_ENABLED);

    always_comb begin
        enabled_next = enabled_reg;
        if (psel && penable && pwrite && pready && sel_enabled) begin
            enabled_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else begin
            enabled_reg <= enabled_next;
        end
    end

    assign prdata  = sel_enabled ? {31'd0, enabled_reg} : 32'd0;
    assign enabled = enabled_reg;

endmodule

@@ src/scs_core.sv @@
module scs_core #(
    parameter int COUNT_BITS = scs_pkg::COUNT_BITS_DEF,
    parameter int TICK_BITS  = scs_pkg::TICK_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             enabled,
    input  logic             advance,
    input  scs_pkg::item_t   item,
    output scs_pkg::result_t result
);

    scs_pkg::cap_state_t   state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    scs_pkg::error_t       err_reg, err_next;
    logic                  raw_reg, raw_next;
    logic                  storage_reg, storage_next;
    logic [TICK_BITS-1:0]  start_reg, start_next;

    logic [TICK_BITS+31:0]  now_ext;
    logic [TICK_BITS-1:0]   now_t;
    logic [TICK_BITS-1:0]   ticks;
    logic [TICK_BITS+31:0]  ticks_ext;
    logic [COUNT_BITS+15:0] count_ext;
    logic [5:0]             code;
    scs_pkg::result_code_t  rc;
    logic                   cv;
    scs_pkg::cmd_id_t       cid;
    logic [7:0]             cpl;
    logic                   start_err;

    assign now_ext = {{TICK_BITS{1'b0}}, item.now_tick};
    assign now_t   = now_ext[TICK_BITS-1:0];
    assign code    = item.status_word[5:0] & scs_pkg::REPORT_CODE_MASK;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        raw_next     = raw_reg;
        storage_next = storage_reg;
        start_next   = start_reg;
        rc           = scs_pkg::RC_OK;
        cv           = 1'b0;
        cid          = scs_pkg::CMD_SINGLE;
        cpl          = 8'd0;
        start_err    = 1'b0;
        if (item.action <= scs_pkg::ACT_RAW && !enabled) begin
            rc = scs_pkg::RC_NOT_ENABLED;
        end else begin
            unique case (item.action)
                scs_pkg::ACT_SINGLE, scs_pkg::ACT_BURST: begin
                    if (state_reg != scs_pkg::ST_IDLE) begin
                        rc = scs_pkg::RC_WRONG_STATE;
                    end else if (!storage_reg) begin
                        rc        = scs_pkg::RC_NO_STORAGE;
                        err_next  = scs_pkg::ERR_NO_STORAGE;
                        start_err = 1'b1;
                    end else if (!item.space_ok) begin
                        rc        = scs_pkg::RC_NO_SPACE;
                        err_next  = scs_pkg::ERR_NO_SPACE;
                        start_err = 1'b1;
                    end else begin
                        cv         = 1'b1;
                        count_next = '0;
                        err_next   = scs_pkg::ERR_NONE;
                        if (item.action == scs_pkg::ACT_BURST) begin
                            cid        = scs_pkg::CMD_BURST;
                            start_next = now_t;
                            state_next = scs_pkg::ST_BURST;
                        end else begin
                            cid        = scs_pkg::CMD_SINGLE;
                            state_next = scs_pkg::ST_SINGLE;
                        end
                    end
                end
                scs_pkg::ACT_STOP: begin
                    if (state_reg != scs_pkg::ST_BURST) begin
                        rc = scs_pkg::RC_WRONG_STATE;
                    end else begin
                        cv         = 1'b1;
                        cid        = scs_pkg::CMD_STOP;
                        cpl        = scs_pkg::STOP_PAYLOAD;
                        state_next = scs_pkg::ST_STOPPING;
                    end
                end
                scs_pkg::ACT_RAW: begin
                    if (state_reg != scs_pkg::ST_IDLE) begin
                        rc = scs_pkg::RC_WRONG_STATE;
                    end else begin
                        raw_next = (item.flags != 8'd0);
                        cv       = 1'b1;
                        cid      = scs_pkg::CMD_RAW;
                        cpl      = item.flags;
                    end
                end
                scs_pkg::ACT_REPORT: begin
                    if (code == scs_pkg::REP_SINGLE_DONE) begin
                        if (state_reg == scs_pkg::ST_IDLE) begin
                            rc = scs_pkg::RC_BAD_REPORT;
                        end else begin
                            if (count_reg != '1) begin
                                count_next = count_reg + 1'b1;
                            end
                            if (state_reg == scs_pkg::ST_SINGLE) begin
                                state_next = scs_pkg::ST_IDLE;
                            end
                        end
                    end else if (code == scs_pkg::REP_BURST_DONE) begin
                        if (state_reg == scs_pkg::ST_BURST
                                || state_reg == scs_pkg::ST_STOPPING) begin
                            state_next = scs_pkg::ST_IDLE;
                        end else begin
                            rc = scs_pkg::RC_BAD_REPORT;
                        end
                    end else if (code >= scs_pkg::REP_CAPTURE_FAIL
                            && code <= scs_pkg::REP_CREATE_FAIL) begin
                        err_next   = scs_pkg::error_t'(code[2:0]);
                        state_next = scs_pkg::ST_IDLE;
                    end else begin
                        rc = scs_pkg::RC_BAD_REPORT;
                    end
                end
                scs_pkg::ACT_STORAGE: begin
                    if (item.storage_ready != storage_reg) begin
                        storage_next = item.storage_ready;
                        cv           = 1'b1;
                        cid          = scs_pkg::CMD_STORAGE;
                        cpl          = {7'd0, item.storage_ready};
                    end
                end
                default: begin
                    rc = scs_pkg::RC_UNKNOWN;
                end
            endcase
        end
    end

    assign ticks = (state_next == scs_pkg::ST_BURST || state_next == scs_pkg::ST_STOPPING)
                   ? (now_t - start_next) : '0;
    assign ticks_ext = {32'd0, ticks};
    assign count_ext = {16'd0, count_next};

    always_comb begin
        result.result_code   = rc;
        result.cmd_valid     = cv;
        result.cmd_id        = cid;
        result.cmd_payload   = cpl;
        result.state_event   = start_err || (state_next != state_reg);
        result.picture_event = (count_next > count_reg);
        result.picture_code  = (count_next > count_reg) ? item.status_word : 16'd0;
        result.cap_state     = state_next;
        result.picture_count = count_ext[15:0];
        result.err_latched   = err_next;
        result.raw_mode      = raw_next;
        result.elapsed_ticks = ticks_ext[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scs_pkg::ST_IDLE;
            count_reg   <= '0;
            err_reg     <= scs_pkg::ERR_NONE;
            raw_reg     <= 1'b0;
            storage_reg <= 1'b0;
            start_reg   <= '0;
        end else if (advance) begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            raw_reg     <= raw_next;
            storage_reg <= storage_next;
            start_reg   <= start_next;
        end
    end

endmodule

@@ src/still_capture_sequencer.sv @@
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while m_tready is high; the registers advance together.
// s_tready stays high while the result register is free or being drained.
// Reset: synchronous on aresetn low; capture state idle, counters, flags, error and
// burst start cleared, service disabled, both pipeline registers empty.
module still_capture_sequencer #(
    parameter int COUNT_BITS = scs_pkg::COUNT_BITS_DEF,
    parameter int TICK_BITS  = scs_pkg::TICK_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // flags[7:0], status_word[23:8], storage_ready[24], space_ok[25], now_tick[57:26]
    input  logic [scs_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // action[2:0]
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_code[2:0], cmd_valid[3], cmd_id[6:4], cmd_payload[14:7], state_event[15],
    // picture_event[16], picture_code[32:17], cap_state[34:33], picture_count[50:35],
    // err_latched[53:51], raw_mode[54], elapsed_ticks[86:55]
    output logic [scs_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scs_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic             enabled;
    logic             in_valid_reg, in_valid_next;
    scs_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    scs_pkg::result_t out_result_reg;
    scs_pkg::result_t result;
    logic             advance;
    logic             s_fire;

    scs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .enabled (enabled)
    );

    scs_core #(
        .COUNT_BITS (COUNT_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enabled (enabled),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload on stall
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.action        <= s_tuser;
            in_item_reg.flags         <= s_tdata[7:0];
            in_item_reg.status_word   <= s_tdata[23:8];
            in_item_reg.storage_ready <= s_tdata[24];
            in_item_reg.space_ok      <= s_tdata[25];
            in_item_reg.now_tick      <= s_tdata[57:26];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.elapsed_ticks,
                       out_result_reg.raw_mode,
                       out_result_reg.err_latched,
                       out_result_reg.picture_count,
                       out_result_reg.cap_state,
                       out_result_reg.picture_code,
                       out_result_reg.picture_event,
                       out_result_reg.state_event,
                       out_result_reg.cmd_payload,
                       out_result_reg.cmd_id,
                       out_result_reg.cmd_valid,
                       out_result_reg.result_code};

endmodule
